[rtl/core/stt_pkg.sv]
// Shared types, constants and character classes for the source text tokenizer.
// Used by stt_lexer, stt_result_fifo and source_text_tokenizer_unit.
// No dependencies.
package stt_pkg;

	// Longest token accepted before the length error fires
	localparam int MAX_TOKEN_LEN = 256;
	localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Token kinds
	localparam logic [2:0] K_ID  = 3'd0;
	localparam logic [2:0] K_NUM = 3'd1;
	localparam logic [2:0] K_OP  = 3'd2;
	localparam logic [2:0] K_SYM = 3'd3;
	localparam logic [2:0] K_STR = 3'd4;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LETTER = 2'd1;
	localparam logic [1:0] ERR_LONG   = 2'd2;

	// Characters with special meaning
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_N     = 8'h6E;

	typedef enum logic [2:0] {
		M_IDLE       = 3'd0,
		M_ID         = 3'd1,
		M_NUM        = 3'd2,
		M_OP         = 3'd3,
		M_STR        = 3'd4,
		M_CMNT       = 3'd5,
		M_ERR_LETTER = 3'd6,
		M_ERR_LONG   = 3'd7
	} lex_mode_t;

	// One result beat
	typedef struct packed {
		logic [2:0] kind;
		logic       char_valid;
		logic [7:0] ch;
		logic       token_end;
		logic [1:0] err;
		logic       last;
	} result_t;

	// Up to two results written into the queue together
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h3E || c == 8'h3C ||
		       c == 8'h3D || c == 8'h21 || c == 8'h2F || c == 8'h26 || c == 8'h7C;
	endfunction

	function automatic logic is_sym(input logic [7:0] c);
		return c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D || c == 8'h3B ||
		       c == 8'h2C || c == 8'h24 || c == 8'h2E || c == 8'h3A;
	endfunction

	function automatic result_t mk_res(input logic [2:0] kind, input logic vld,
	                                   input logic [7:0] ch, input logic tend,
	                                   input logic [1:0] err);
		result_t r;
		r.kind       = kind;
		r.char_valid = vld;
		r.ch         = vld ? ch : 8'h00;
		r.token_end  = tend;
		r.err        = err;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

[rtl/core/stt_lexer.sv]
// Input register and lexer state: classifies one byte per cycle while
// the queue has room, building up to two result beats. Depends on stt_pkg.
module stt_lexer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  logic [7:0]          text_char,
	input  logic                end_of_text,
	input  logic                room,
	output stt_pkg::push_t      push
);

	logic                          valid_s1;
	logic [7:0]                    char_s1;
	logic                          eot_s1;
	logic                          adv;

	stt_pkg::lex_mode_t            mode_q, mode_d;
	logic [7:0]                    held_q, held_d;
	logic [stt_pkg::LEN_W-1:0]     len_q, len_d;
	logic                          esc_q, esc_d;
	logic                          star_q, star_d;

	// Start-of-token view of the current byte
	stt_pkg::lex_mode_t            st_mode;
	logic [stt_pkg::LEN_W-1:0]     st_len;
	logic                          st_has;
	stt_pkg::result_t              st_res;

	stt_pkg::result_t              r0, r1;
	logic [1:0]                    n;

	assign adv        = valid_s1 & room;
	assign text_stall = valid_s1 & ~room;

	// Input register: take a beat whenever the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			char_s1 <= text_char;
			eot_s1  <= end_of_text;
		end
	end

	// Classify the byte as the first of a fresh token
	always_comb begin
		st_mode = stt_pkg::M_IDLE;
		st_len  = '0;
		st_has  = 1'b0;
		st_res  = stt_pkg::mk_res(stt_pkg::K_ID, 1'b0, 8'h00, 1'b0, stt_pkg::ERR_NONE);
		priority if (stt_pkg::is_letter(char_s1)) begin
			st_mode = stt_pkg::M_ID;
			st_len  = stt_pkg::LEN_W'(1);
			st_has  = 1'b1;
			st_res  = stt_pkg::mk_res(stt_pkg::K_ID, 1'b1, char_s1, 1'b0, stt_pkg::ERR_NONE);
		end else if (stt_pkg::is_digit(char_s1)) begin
			st_mode = stt_pkg::M_NUM;
			st_len  = stt_pkg::LEN_W'(1);
			st_has  = 1'b1;
			st_res  = stt_pkg::mk_res(stt_pkg::K_NUM, 1'b1, char_s1, 1'b0, stt_pkg::ERR_NONE);
		end else if (stt_pkg::is_op(char_s1)) begin
			st_mode = stt_pkg::M_OP;
			st_len  = stt_pkg::LEN_W'(1);
		end else if (stt_pkg::is_sym(char_s1)) begin
			st_has  = 1'b1;
			st_res  = stt_pkg::mk_res(stt_pkg::K_SYM, 1'b1, char_s1, 1'b1, stt_pkg::ERR_NONE);
		end else if (char_s1 == stt_pkg::CH_QUOTE) begin
			st_mode = stt_pkg::M_STR;
		end else begin
			// Skip whitespace and unknown bytes
		end
	end

	// Next state and results for the byte in the input register
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		len_d  = len_q;
		esc_d  = esc_q;
		star_d = star_q;
		r0     = stt_pkg::mk_res(stt_pkg::K_ID, 1'b0, 8'h00, 1'b0, stt_pkg::ERR_NONE);
		r1     = r0;
		n      = 2'd0;

		priority if (mode_q == stt_pkg::M_ERR_LETTER) begin
			r0 = stt_pkg::mk_res(stt_pkg::K_ID, 1'b0, 8'h00, 1'b0, stt_pkg::ERR_LETTER);
			n  = 2'd1;
		end else if (mode_q == stt_pkg::M_ERR_LONG) begin
			r0 = stt_pkg::mk_res(stt_pkg::K_ID, 1'b0, 8'h00, 1'b0, stt_pkg::ERR_LONG);
			n  = 2'd1;
		end else if (eot_s1) begin
			// Flush the pending token and go idle
			unique case (mode_q)
				stt_pkg::M_ID: begin
					r0 = stt_pkg::mk_res(stt_pkg::K_ID, 1'b0, 8'h00, 1'b1, stt_pkg::ERR_NONE);
					n  = 2'd1;
				end
				stt_pkg::M_NUM: begin
					r0 = stt_pkg::mk_res(stt_pkg::K_NUM, 1'b0, 8'h00, 1'b1, stt_pkg::ERR_NONE);
					n  = 2'd1;
				end
				stt_pkg::M_OP: begin
					r0 = stt_pkg::mk_res(stt_pkg::K_OP, 1'b1, held_q, 1'b1, stt_pkg::ERR_NONE);
					n  = 2'd1;
				end
				stt_pkg::M_STR: begin
					r0 = stt_pkg::mk_res(stt_pkg::K_STR, 1'b0, 8'h00, 1'b1, stt_pkg::ERR_NONE);
					n  = 2'd1;
				end
				default: begin
				end
			endcase
			mode_d = stt_pkg::M_IDLE;
			len_d  = '0;
			esc_d  = 1'b0;
			star_d = 1'b0;
		end else if (mode_q != stt_pkg::M_IDLE && mode_q != stt_pkg::M_CMNT &&
		             len_q >= stt_pkg::LEN_W'(stt_pkg::MAX_TOKEN_LEN)) begin
			mode_d = stt_pkg::M_ERR_LONG;
			r0     = stt_pkg::mk_res(stt_pkg::K_ID, 1'b0, 8'h00, 1'b0, stt_pkg::ERR_LONG);
			n      = 2'd1;
		end else begin
			unique case (mode_q)
				stt_pkg::M_ID: begin
					if (stt_pkg::is_letter(char_s1) || stt_pkg::is_digit(char_s1)) begin
						len_d = len_q + stt_pkg::LEN_W'(1);
						r0    = stt_pkg::mk_res(stt_pkg::K_ID, 1'b1, char_s1, 1'b0,
						                        stt_pkg::ERR_NONE);
						n     = 2'd1;
					end else begin
						r0 = stt_pkg::mk_res(stt_pkg::K_ID, 1'b0, 8'h00, 1'b1,
						                     stt_pkg::ERR_NONE);
						r1 = st_res;
						n  = st_has ? 2'd2 : 2'd1;
						mode_d = st_mode;
						len_d  = st_len;
						esc_d  = 1'b0;
						star_d = 1'b0;
						if (st_mode == stt_pkg::M_OP) begin
							held_d = char_s1;
						end
					end
				end
				stt_pkg::M_NUM: begin
					priority if (stt_pkg::is_digit(char_s1)) begin
						len_d = len_q + stt_pkg::LEN_W'(1);
						r0    = stt_pkg::mk_res(stt_pkg::K_NUM, 1'b1, char_s1, 1'b0,
						                        stt_pkg::ERR_NONE);
						n     = 2'd1;
					end else if (stt_pkg::is_letter(char_s1)) begin
						mode_d = stt_pkg::M_ERR_LETTER;
						r0     = stt_pkg::mk_res(stt_pkg::K_NUM, 1'b0, 8'h00, 1'b0,
						                         stt_pkg::ERR_LETTER);
						n      = 2'd1;
					end else begin
						r0 = stt_pkg::mk_res(stt_pkg::K_NUM, 1'b0, 8'h00, 1'b1,
						                     stt_pkg::ERR_NONE);
						r1 = st_res;
						n  = st_has ? 2'd2 : 2'd1;
						mode_d = st_mode;
						len_d  = st_len;
						esc_d  = 1'b0;
						star_d = 1'b0;
						if (st_mode == stt_pkg::M_OP) begin
							held_d = char_s1;
						end
					end
				end
				stt_pkg::M_OP: begin
					priority if (char_s1 == stt_pkg::CH_STAR &&
					             held_q == stt_pkg::CH_SLASH) begin
						// Comment opener: close any text before the slash, drop the slash
						if (len_q > stt_pkg::LEN_W'(1)) begin
							r0 = stt_pkg::mk_res(stt_pkg::K_OP, 1'b0, 8'h00, 1'b1,
							                     stt_pkg::ERR_NONE);
							n  = 2'd1;
						end
						mode_d = stt_pkg::M_CMNT;
						len_d  = '0;
						star_d = 1'b0;
					end else if (stt_pkg::is_op(char_s1)) begin
						r0     = stt_pkg::mk_res(stt_pkg::K_OP, 1'b1, held_q, 1'b0,
						                         stt_pkg::ERR_NONE);
						n      = 2'd1;
						held_d = char_s1;
						len_d  = len_q + stt_pkg::LEN_W'(1);
					end else begin
						r0 = stt_pkg::mk_res(stt_pkg::K_OP, 1'b1, held_q, 1'b1,
						                     stt_pkg::ERR_NONE);
						r1 = st_res;
						n  = st_has ? 2'd2 : 2'd1;
						mode_d = st_mode;
						len_d  = st_len;
						esc_d  = 1'b0;
						star_d = 1'b0;
					end
				end
				stt_pkg::M_STR: begin
					priority if (esc_q) begin
						esc_d = 1'b0;
						if (char_s1 == stt_pkg::CH_N) begin
							len_d = len_q + stt_pkg::LEN_W'(1);
							r0    = stt_pkg::mk_res(stt_pkg::K_STR, 1'b1, stt_pkg::CH_NL,
							                        1'b0, stt_pkg::ERR_NONE);
							n     = 2'd1;
						end else if (char_s1 == stt_pkg::CH_BSL) begin
							len_d = len_q + stt_pkg::LEN_W'(1);
							r0    = stt_pkg::mk_res(stt_pkg::K_STR, 1'b1, stt_pkg::CH_BSL,
							                        1'b0, stt_pkg::ERR_NONE);
							n     = 2'd1;
						end
					end else if (char_s1 == stt_pkg::CH_QUOTE) begin
						r0     = stt_pkg::mk_res(stt_pkg::K_STR, 1'b0, 8'h00, 1'b1,
						                         stt_pkg::ERR_NONE);
						n      = 2'd1;
						mode_d = stt_pkg::M_IDLE;
						len_d  = '0;
					end else if (char_s1 == stt_pkg::CH_BSL) begin
						esc_d = 1'b1;
					end else if (char_s1 != stt_pkg::CH_NL) begin
						len_d = len_q + stt_pkg::LEN_W'(1);
						r0    = stt_pkg::mk_res(stt_pkg::K_STR, 1'b1, char_s1, 1'b0,
						                        stt_pkg::ERR_NONE);
						n     = 2'd1;
					end else begin
						// Drop a raw newline
					end
				end
				stt_pkg::M_CMNT: begin
					if (char_s1 == stt_pkg::CH_SLASH && star_q) begin
						mode_d = stt_pkg::M_IDLE;
						star_d = 1'b0;
					end else begin
						star_d = (char_s1 == stt_pkg::CH_STAR);
					end
				end
				default: begin
					// Idle between tokens
					r0     = st_res;
					n      = st_has ? 2'd1 : 2'd0;
					mode_d = st_mode;
					len_d  = st_len;
					esc_d  = 1'b0;
					star_d = 1'b0;
					if (st_mode == stt_pkg::M_OP) begin
						held_d = char_s1;
					end
				end
			endcase
		end

		// Mark the final beat of this byte
		r0.last = (n == 2'd1);
		r1.last = (n == 2'd2);

		push.count = adv ? n : 2'd0;
		push.r0    = r0;
		push.r1    = r1;
	end

	// Lexer state: advance only when the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::M_IDLE;
			held_q <= 8'h00;
			len_q  <= '0;
			esc_q  <= 1'b0;
			star_q <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			held_q <= held_d;
			len_q  <= len_d;
			esc_q  <= esc_d;
			star_q <= star_d;
		end
	end

endmodule

[rtl/core/stt_result_fifo.sv]
// Small result queue: takes up to two beats per cycle, gives one per cycle unless stalled.
// Depends on stt_pkg.
module stt_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  stt_pkg::push_t     push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output stt_pkg::result_t   out_res
);

	stt_pkg::result_t           mem [stt_pkg::FIFO_DEPTH];
	logic [stt_pkg::PTR_W-1:0]  wr_q, rd_q;
	logic [stt_pkg::CNT_W-1:0]  cnt_q;
	logic                       pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign out_res   = mem[rd_q];

	// Room for a full pair of beats from the lexer
	assign room = (cnt_q <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH - 2));

	// Write the beats of one byte
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + stt_pkg::PTR_W'(1)] <= push.r1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + stt_pkg::PTR_W'(push.count);
			if (pop) begin
				rd_q <= rd_q + stt_pkg::PTR_W'(1);
			end
			cnt_q <= cnt_q + stt_pkg::CNT_W'(push.count) - stt_pkg::CNT_W'(pop);
		end
	end

endmodule

[rtl/core/source_text_tokenizer_unit.sv]
// Top level of the source text tokenizer: lexer stage plus result queue.
// Depends on stt_pkg, stt_lexer and stt_result_fifo.
//
//   channel   handshake                    payload
//   text      text_valid / text_stall      text_char, end_of_text
//   result    result_valid / result_stall  tok_kind, char_valid, char_out,
//                                          token_end, error_code, last_result
//
// A byte enters the input register and is classified there. When the queue
// has room, its zero, one or two result beats are written into a four-entry
// queue, from whose head they reach the result port. A byte giving two
// results is handed out as two separate beats. One byte per cycle is taken
// while the queue holds two or fewer beats. Reset clears the lexer to idle and
// empties the queue.
module source_text_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_char,
	input  logic       end_of_text,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] tok_kind,
	output logic       char_valid,
	output logic [7:0] char_out,
	output logic       token_end,
	output logic [1:0] error_code,
	output logic       last_result
);

	stt_pkg::push_t    push;
	stt_pkg::result_t  res;
	logic              room;

	stt_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_char   (text_char),
		.end_of_text (end_of_text),
		.room        (room),
		.push        (push)
	);

	stt_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_res   (res)
	);

	// Unpack the head beat onto the ports
	assign tok_kind    = res.kind;
	assign char_valid  = res.char_valid;
	assign char_out    = res.ch;
	assign token_end   = res.token_end;
	assign error_code  = res.err;
	assign last_result = res.last;

endmodule
